### rtl/ouc_pkg.sv
// shared widths, constants and stage payload types for the unwarp coordinate map
`default_nettype none
package ouc_pkg;

  localparam int IN_W     = 12;           // col_offset, row_offset
  localparam int OFFSET_BITS = 12;        // src_dx, src_dy
  localparam int HORIZON  = 269;
  localparam int NREG     = 8;
  localparam int CFG_AW   = $clog2(NREG);
  localparam int CFG_DW   = 32;
  localparam int PW       = IN_W + CFG_DW;      // one basis product
  localparam int SW       = PW + 2;             // ray component
  localparam int MW       = 31;                 // normalized magnitude
  localparam int SHW      = $clog2(SW - MW + 1);
  localparam int SQW      = 2 * MW + 2;         // sum of three squares
  localparam int RTW      = SQW / 2;            // square root
  localparam int SQ_RW    = RTW + 2;            // sqrt partial remainder
  localparam int DW       = RTW + 1;            // positive denominator
  localparam int HW       = $clog2(HORIZON + 1);
  localparam int NW       = MW + HW;            // HORIZON * magnitude
  localparam int QW       = OFFSET_BITS + 1;    // quotient bits kept
  localparam int CW       = DW + QW;            // divisor compare width

  localparam logic [CFG_AW-1:0] REG_ORIGIN_X     = CFG_AW'(0);
  localparam logic [CFG_AW-1:0] REG_ORIGIN_Y     = CFG_AW'(1);
  localparam logic [CFG_AW-1:0] REG_ORIGIN_Z     = CFG_AW'(2);
  localparam logic [CFG_AW-1:0] REG_HORIZ_STEP_X = CFG_AW'(3);
  localparam logic [CFG_AW-1:0] REG_HORIZ_STEP_Y = CFG_AW'(4);
  localparam logic [CFG_AW-1:0] REG_VERT_STEP_X  = CFG_AW'(5);
  localparam logic [CFG_AW-1:0] REG_VERT_STEP_Y  = CFG_AW'(6);
  localparam logic [CFG_AW-1:0] REG_VERT_STEP_Z  = CFG_AW'(7);

  typedef struct packed {
    logic [SQW-1:0]   rad;
    logic [SQ_RW-1:0] rem;
    logic [RTW-1:0]   root;
    logic [MW-1:0]    nx;
    logic [MW-1:0]    ny;
    logic [MW-1:0]    nz;
    logic             sx;
    logic             sy;
    logic             zn;
  } sqrt_stage_t;

  typedef struct packed {
    logic [NW-1:0] rx;
    logic [NW-1:0] ry;
    logic [DW-1:0] d;
    logic [QW-1:0] qx;
    logic [QW-1:0] qy;
    logic          ovx;
    logic          ovy;
    logic          sx;
    logic          sy;
    logic          inv;
  } div_stage_t;

endpackage
`default_nettype wire

### rtl/omni_unwarp_coordinate_map.sv
// pipelined ray projection from view offsets to mirror source offsets
//
//  channel  | direction | contents
//  in_      | request   | tdata: col_offset[11:0], row_offset[23:12]
//  out_     | result    | tdata: src_dx[11:0], src_dy[23:12]; tuser: invalid[0], clipped[1]
//  cfg_     | write     | cfg_addr selects one of eight Q16.16 registers
//
// one request per cycle while out_tready does not stall the pipe; depth is set by
// the 32-step square root and the 13-step divider, one step per stage.
// reset clears valid bits and loads the register defaults.
// a stall on out_tready freezes every stage together; nothing is dropped.
`default_nettype none
module omni_unwarp_coordinate_map (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              in_tvalid,
  output logic                             in_tready,
  input  wire  [2*ouc_pkg::IN_W-1:0]       in_tdata,   // col_offset, row_offset
  output logic                             out_tvalid,
  input  wire                              out_tready,
  output logic [2*ouc_pkg::OFFSET_BITS-1:0] out_tdata, // src_dx, src_dy
  output logic [1:0]                       out_tuser,  // invalid, clipped
  input  wire                              cfg_we,
  input  wire  [ouc_pkg::CFG_AW-1:0]       cfg_addr,
  input  wire  [ouc_pkg::CFG_DW-1:0]       cfg_data
);

  localparam int NSQ = ouc_pkg::RTW;
  localparam int NDV = ouc_pkg::QW;

  logic signed [ouc_pkg::CFG_DW-1:0] cfg_r [ouc_pkg::NREG];
  logic en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r[ouc_pkg::REG_ORIGIN_X]     <= 32'sd0;
      cfg_r[ouc_pkg::REG_ORIGIN_Y]     <= 32'sd0;
      cfg_r[ouc_pkg::REG_ORIGIN_Z]     <= 32'sd17629184;
      cfg_r[ouc_pkg::REG_HORIZ_STEP_X] <= 32'sd65536;
      cfg_r[ouc_pkg::REG_HORIZ_STEP_Y] <= 32'sd0;
      cfg_r[ouc_pkg::REG_VERT_STEP_X]  <= 32'sd0;
      cfg_r[ouc_pkg::REG_VERT_STEP_Y]  <= 32'sd65536;
      cfg_r[ouc_pkg::REG_VERT_STEP_Z]  <= 32'sd0;
    end else if (cfg_we) begin
      cfg_r[cfg_addr] <= cfg_data;
    end
  end

  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  // stage 1: basis products
  logic signed [ouc_pkg::IN_W-1:0] col_s, row_s;
  logic signed [ouc_pkg::PW-1:0] pcx_r, prx_r, pcy_r, pry_r, prz_r;
  logic v1_r;
  assign col_s = in_tdata[ouc_pkg::IN_W-1:0];
  assign row_s = in_tdata[2*ouc_pkg::IN_W-1:ouc_pkg::IN_W];

  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else if (en) v1_r <= in_tvalid;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      pcx_r <= ouc_pkg::PW'(col_s) * ouc_pkg::PW'(cfg_r[ouc_pkg::REG_HORIZ_STEP_X]);
      prx_r <= ouc_pkg::PW'(row_s) * ouc_pkg::PW'(cfg_r[ouc_pkg::REG_VERT_STEP_X]);
      pcy_r <= ouc_pkg::PW'(col_s) * ouc_pkg::PW'(cfg_r[ouc_pkg::REG_HORIZ_STEP_Y]);
      pry_r <= ouc_pkg::PW'(row_s) * ouc_pkg::PW'(cfg_r[ouc_pkg::REG_VERT_STEP_Y]);
      prz_r <= ouc_pkg::PW'(row_s) * ouc_pkg::PW'(cfg_r[ouc_pkg::REG_VERT_STEP_Z]);
    end
  end

  // stage 2: ray components
  logic signed [ouc_pkg::SW-1:0] px_r, py_r, pz_r;
  logic v2_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else if (en) v2_r <= v1_r;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      px_r <= ouc_pkg::SW'(cfg_r[ouc_pkg::REG_ORIGIN_X]) + ouc_pkg::SW'(pcx_r)
              + ouc_pkg::SW'(prx_r);
      py_r <= ouc_pkg::SW'(cfg_r[ouc_pkg::REG_ORIGIN_Y]) + ouc_pkg::SW'(pcy_r)
              + ouc_pkg::SW'(pry_r);
      pz_r <= ouc_pkg::SW'(cfg_r[ouc_pkg::REG_ORIGIN_Z]) + ouc_pkg::SW'(prz_r);
    end
  end

  // stage 3: magnitudes and signs
  logic [ouc_pkg::SW-1:0] mx_r, my_r, mz_r;
  logic sx3_r, sy3_r, zn3_r, v3_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v3_r <= 1'b0;
    else if (en) v3_r <= v2_r;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      mx_r  <= px_r[ouc_pkg::SW-1] ? ouc_pkg::SW'(-px_r) : ouc_pkg::SW'(px_r);
      my_r  <= py_r[ouc_pkg::SW-1] ? ouc_pkg::SW'(-py_r) : ouc_pkg::SW'(py_r);
      mz_r  <= pz_r[ouc_pkg::SW-1] ? ouc_pkg::SW'(-pz_r) : ouc_pkg::SW'(pz_r);
      sx3_r <= px_r[ouc_pkg::SW-1];
      sy3_r <= py_r[ouc_pkg::SW-1];
      zn3_r <= pz_r[ouc_pkg::SW-1];
    end
  end

  // stage 4: common right shift so the largest fits in MW bits
  logic [ouc_pkg::SW-1:0] mor;
  logic [ouc_pkg::SHW-1:0] sh;
  logic [ouc_pkg::MW-1:0] nx4_r, ny4_r, nz4_r;
  logic sx4_r, sy4_r, zn4_r, v4_r;
  logic [ouc_pkg::SW-1:0] shx, shy, shz;
  always_comb begin
    mor = mx_r | my_r | mz_r;
    sh  = '0;
    for (int j = ouc_pkg::MW; j < ouc_pkg::SW; j++) begin
      if (mor[j]) sh = ouc_pkg::SHW'(j - ouc_pkg::MW + 1);
    end
    shx = mx_r >> sh;
    shy = my_r >> sh;
    shz = mz_r >> sh;
  end
  always_ff @(posedge clk) begin
    if (!rst_n) v4_r <= 1'b0;
    else if (en) v4_r <= v3_r;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      nx4_r <= shx[ouc_pkg::MW-1:0];
      ny4_r <= shy[ouc_pkg::MW-1:0];
      nz4_r <= shz[ouc_pkg::MW-1:0];
      sx4_r <= sx3_r;
      sy4_r <= sy3_r;
      zn4_r <= zn3_r;
    end
  end

  // stage 5: squares
  logic [2*ouc_pkg::MW-1:0] qx5_r, qy5_r, qz5_r;
  logic [ouc_pkg::MW-1:0] nx5_r, ny5_r, nz5_r;
  logic sx5_r, sy5_r, zn5_r, v5_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v5_r <= 1'b0;
    else if (en) v5_r <= v4_r;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      qx5_r <= (2*ouc_pkg::MW)'(nx4_r) * (2*ouc_pkg::MW)'(nx4_r);
      qy5_r <= (2*ouc_pkg::MW)'(ny4_r) * (2*ouc_pkg::MW)'(ny4_r);
      qz5_r <= (2*ouc_pkg::MW)'(nz4_r) * (2*ouc_pkg::MW)'(nz4_r);
      nx5_r <= nx4_r;
      ny5_r <= ny4_r;
      nz5_r <= nz4_r;
      sx5_r <= sx4_r;
      sy5_r <= sy4_r;
      zn5_r <= zn4_r;
    end
  end

  // stage 6 and square root steps, one result bit per stage
  ouc_pkg::sqrt_stage_t sq_r [NSQ+1];
  logic                 vsq_r [NSQ+1];

  always_ff @(posedge clk) begin
    if (!rst_n) vsq_r[0] <= 1'b0;
    else if (en) vsq_r[0] <= v5_r;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      sq_r[0].rad  <= ouc_pkg::SQW'(qx5_r) + ouc_pkg::SQW'(qy5_r) + ouc_pkg::SQW'(qz5_r);
      sq_r[0].rem  <= '0;
      sq_r[0].root <= '0;
      sq_r[0].nx   <= nx5_r;
      sq_r[0].ny   <= ny5_r;
      sq_r[0].nz   <= nz5_r;
      sq_r[0].sx   <= sx5_r;
      sq_r[0].sy   <= sy5_r;
      sq_r[0].zn   <= zn5_r;
    end
  end

  for (genvar i = 0; i < NSQ; i++) begin : g_sqrt
    logic [ouc_pkg::SQ_RW+1:0] cand, trial;
    ouc_pkg::sqrt_stage_t st_nxt;
    always_comb begin
      st_nxt     = sq_r[i];
      cand       = {sq_r[i].rem, sq_r[i].rad[ouc_pkg::SQW-1 -: 2]};
      trial      = {2'b00, sq_r[i].root, 2'b01};
      st_nxt.rad = sq_r[i].rad << 2;
      if (cand >= trial) begin
        st_nxt.rem  = ouc_pkg::SQ_RW'(cand - trial);
        st_nxt.root = {sq_r[i].root[ouc_pkg::RTW-2:0], 1'b1};
      end else begin
        st_nxt.rem  = ouc_pkg::SQ_RW'(cand);
        st_nxt.root = {sq_r[i].root[ouc_pkg::RTW-2:0], 1'b0};
      end
    end
    always_ff @(posedge clk) begin
      if (!rst_n) vsq_r[i+1] <= 1'b0;
      else if (en) vsq_r[i+1] <= vsq_r[i];
    end
    always_ff @(posedge clk) begin
      if (en) sq_r[i+1] <= st_nxt;
    end
  end

  // denominator and numerators
  ouc_pkg::div_stage_t dv_r [NDV+1];
  logic                vdv_r [NDV+1];
  logic signed [ouc_pkg::DW:0] dsum;
  logic dinv;
  always_comb begin
    if (sq_r[NSQ].zn)
      dsum = $signed({1'b0, 1'b0, sq_r[NSQ].root})
             - $signed((ouc_pkg::DW+1)'(sq_r[NSQ].nz));
    else
      dsum = $signed({1'b0, 1'b0, sq_r[NSQ].root})
             + $signed((ouc_pkg::DW+1)'(sq_r[NSQ].nz));
    dinv = dsum[ouc_pkg::DW] || (dsum == '0);
  end
  always_ff @(posedge clk) begin
    if (!rst_n) vdv_r[0] <= 1'b0;
    else if (en) vdv_r[0] <= vsq_r[NSQ];
  end
  always_ff @(posedge clk) begin
    if (en) begin
      dv_r[0].rx  <= ouc_pkg::NW'(ouc_pkg::HORIZON) * ouc_pkg::NW'(sq_r[NSQ].nx);
      dv_r[0].ry  <= ouc_pkg::NW'(ouc_pkg::HORIZON) * ouc_pkg::NW'(sq_r[NSQ].ny);
      dv_r[0].d   <= dinv ? ouc_pkg::DW'(1) : dsum[ouc_pkg::DW-1:0];
      dv_r[0].qx  <= '0;
      dv_r[0].qy  <= '0;
      dv_r[0].ovx <= 1'b0;
      dv_r[0].ovy <= 1'b0;
      dv_r[0].sx  <= sq_r[NSQ].sx;
      dv_r[0].sy  <= sq_r[NSQ].sy;
      dv_r[0].inv <= dinv;
    end
  end

  // restoring division, most significant quotient bit first
  for (genvar k = 0; k < NDV; k++) begin : g_div
    localparam int B = NDV - 1 - k;
    logic [ouc_pkg::CW-1:0] dsh, rxw, ryw;
    ouc_pkg::div_stage_t dt_nxt;
    always_comb begin
      dt_nxt = dv_r[k];
      dsh    = ouc_pkg::CW'(dv_r[k].d) << B;
      rxw    = ouc_pkg::CW'(dv_r[k].rx);
      ryw    = ouc_pkg::CW'(dv_r[k].ry);
      if (k == 0) begin
        // quotient too large for the kept bits
        dt_nxt.ovx = rxw >= (ouc_pkg::CW'(dv_r[k].d) << ouc_pkg::QW);
        dt_nxt.ovy = ryw >= (ouc_pkg::CW'(dv_r[k].d) << ouc_pkg::QW);
      end
      if (rxw >= dsh) begin
        dt_nxt.rx    = ouc_pkg::NW'(rxw - dsh);
        dt_nxt.qx[B] = 1'b1;
      end
      if (ryw >= dsh) begin
        dt_nxt.ry    = ouc_pkg::NW'(ryw - dsh);
        dt_nxt.qy[B] = 1'b1;
      end
    end
    always_ff @(posedge clk) begin
      if (!rst_n) vdv_r[k+1] <= 1'b0;
      else if (en) vdv_r[k+1] <= vdv_r[k];
    end
    always_ff @(posedge clk) begin
      if (en) dv_r[k+1] <= dt_nxt;
    end
  end

  // saturation and output register
  localparam logic [ouc_pkg::QW-1:0] HALF = ouc_pkg::QW'(1) << (ouc_pkg::OFFSET_BITS - 1);
  logic [ouc_pkg::OFFSET_BITS-1:0] dx_nxt, dy_nxt;
  logic clx, cly;
  logic [ouc_pkg::QW-1:0] mgx, mgy;
  always_comb begin
    clx = dv_r[NDV].ovx || (dv_r[NDV].sx ? (dv_r[NDV].qx > HALF)
                                         : (dv_r[NDV].qx > HALF - 1'b1));
    cly = dv_r[NDV].ovy || (dv_r[NDV].sy ? (dv_r[NDV].qy > HALF)
                                         : (dv_r[NDV].qy > HALF - 1'b1));
    mgx = clx ? (dv_r[NDV].sx ? HALF : HALF - 1'b1) : dv_r[NDV].qx;
    mgy = cly ? (dv_r[NDV].sy ? HALF : HALF - 1'b1) : dv_r[NDV].qy;
    dx_nxt = dv_r[NDV].sx ? ouc_pkg::OFFSET_BITS'(-mgx) : ouc_pkg::OFFSET_BITS'(mgx);
    dy_nxt = dv_r[NDV].sy ? ouc_pkg::OFFSET_BITS'(-mgy) : ouc_pkg::OFFSET_BITS'(mgy);
  end

  logic out_valid_r;
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (en) out_valid_r <= vdv_r[NDV];
  end
  always_ff @(posedge clk) begin
    if (en) begin
      if (dv_r[NDV].inv) begin
        out_tdata <= '0;
        out_tuser <= 2'b01;
      end else begin
        out_tdata <= {dy_nxt, dx_nxt};
        out_tuser <= {clx || cly, 1'b0};
      end
    end
  end
  assign out_tvalid = out_valid_r;

endmodule
`default_nettype wire

### tb/tb_top.sv
// self-checking testbench for the unwarp coordinate map: predicted offsets vs. stream results
`timescale 1ns / 1ps
module tb_top;
  import ouc_pkg::*;

  typedef struct packed {
    logic [OFFSET_BITS-1:0] dx;
    logic [OFFSET_BITS-1:0] dy;
    logic                   inv;
    logic                   clip;
  } src_pos_t;

  localparam int LATENCY   = 53;
  localparam int IDLE_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [2*IN_W-1:0] in_tdata = '0;         // col_offset[11:0], row_offset[23:12]
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [2*OFFSET_BITS-1:0] out_tdata;      // src_dx[11:0], src_dy[23:12]
  logic [1:0] out_tuser;                    // invalid[0], clipped[1]
  logic cfg_we = 1'b0;
  logic [CFG_AW-1:0] cfg_addr = '0;
  logic [CFG_DW-1:0] cfg_data = '0;

  int view_reg [NREG];
  src_pos_t pending_pos [$];
  int errors = 0;
  int idle_cycles = 0;
  int stall_mode = 0;

  always #5 clk = ~clk;

  omni_unwarp_coordinate_map u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data)
  );

  function automatic longint unsigned root_floor(longint unsigned n);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n = n - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic logic [OFFSET_BITS-1:0] clamp_offset(longint unsigned q, bit neg,
                                                          inout bit clip);
    longint unsigned half;
    longint v;
    half = 64'd1 << (OFFSET_BITS - 1);
    if (neg) begin
      if (q > half) begin q = half; clip = 1'b1; end
      v = -longint'(q);
    end else begin
      if (q > half - 1) begin q = half - 1; clip = 1'b1; end
      v = longint'(q);
    end
    return v[OFFSET_BITS-1:0];
  endfunction

  function automatic src_pos_t project_ray(logic [2*IN_W-1:0] pix);
    longint col, row, px, py, pz, d;
    longint unsigned mx, my, mz, mmax, r;
    bit clip;
    src_pos_t res;
    col = longint'($signed(pix[IN_W-1:0]));
    row = longint'($signed(pix[2*IN_W-1:IN_W]));
    px = longint'(view_reg[REG_ORIGIN_X]) + col * longint'(view_reg[REG_HORIZ_STEP_X])
         + row * longint'(view_reg[REG_VERT_STEP_X]);
    py = longint'(view_reg[REG_ORIGIN_Y]) + col * longint'(view_reg[REG_HORIZ_STEP_Y])
         + row * longint'(view_reg[REG_VERT_STEP_Y]);
    pz = longint'(view_reg[REG_ORIGIN_Z]) + row * longint'(view_reg[REG_VERT_STEP_Z]);
    mx = (px < 0) ? -px : px;
    my = (py < 0) ? -py : py;
    mz = (pz < 0) ? -pz : pz;
    mmax = mx;
    if (my > mmax) mmax = my;
    if (mz > mmax) mmax = mz;
    // scale down until every magnitude fits 31 bits
    while (mmax >= (64'd1 << 31)) begin
      mx = mx >> 1; my = my >> 1; mz = mz >> 1; mmax = mmax >> 1;
    end
    r = root_floor(mx * mx + my * my + mz * mz);
    d = (pz >= 0) ? longint'(r) + longint'(mz) : longint'(r) - longint'(mz);
    res = '0;
    if (d <= 0) begin
      res.inv = 1'b1;
      return res;
    end
    clip = 1'b0;
    res.dx = clamp_offset((HORIZON * mx) / d, px < 0, clip);
    res.dy = clamp_offset((HORIZON * my) / d, py < 0, clip);
    res.clip = clip;
    return res;
  endfunction

  // expectation is formed with the configuration live at acceptance
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) pending_pos.push_back(project_ray(in_tdata));
  end

  always @(posedge clk) begin
    src_pos_t exp_pos, got;
    if (rst_n && out_tvalid && out_tready) begin
      got.dx = out_tdata[OFFSET_BITS-1:0];
      got.dy = out_tdata[2*OFFSET_BITS-1:OFFSET_BITS];
      got.inv = out_tuser[0];
      got.clip = out_tuser[1];
      if (pending_pos.size() == 0) begin
        $display("%0t: unexpected result dx=%0d dy=%0d inv=%0b clip=%0b", $time,
                 $signed(got.dx), $signed(got.dy), got.inv, got.clip);
        errors++;
      end else begin
        exp_pos = pending_pos.pop_front();
        if (got.dx !== exp_pos.dx) begin
          $display("%0t: src_dx expected %0d actual %0d", $time, $signed(exp_pos.dx),
                   $signed(got.dx));
          errors++;
        end
        if (got.dy !== exp_pos.dy) begin
          $display("%0t: src_dy expected %0d actual %0d", $time, $signed(exp_pos.dy),
                   $signed(got.dy));
          errors++;
        end
        if (got.inv !== exp_pos.inv) begin
          $display("%0t: invalid expected %0b actual %0b", $time, exp_pos.inv, got.inv);
          errors++;
        end
        if (got.clip !== exp_pos.clip) begin
          $display("%0t: clipped expected %0b actual %0b", $time, exp_pos.clip, got.clip);
          errors++;
        end
      end
    end
  end

  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // receiver backpressure, changing character now and then; the last mode gives long stalls
  always @(posedge clk) begin
    if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 2);
    case (stall_mode)
      0: out_tready <= 1'b1;
      1: out_tready <= ($urandom_range(0, 3) != 0);
      default: out_tready <= ($urandom_range(0, 30) == 0);
    endcase
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("** omni_unwarp_coordinate_map: FAILED **");
      $finish;
    end
  end

  task automatic send_pixel(logic [IN_W-1:0] col, logic [IN_W-1:0] row);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {row, col};
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (pending_pos.size() != 0) @(posedge clk);
    repeat (LATENCY + 8) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_AW-1:0] idx, int value);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    view_reg[idx] = value;
    @(posedge clk);
  endtask

  task automatic load_view(int ox, int oy, int oz, int hx, int hy, int vx, int vy, int vz);
    write_reg(REG_ORIGIN_X, ox);
    write_reg(REG_ORIGIN_Y, oy);
    write_reg(REG_ORIGIN_Z, oz);
    write_reg(REG_HORIZ_STEP_X, hx);
    write_reg(REG_HORIZ_STEP_Y, hy);
    write_reg(REG_VERT_STEP_X, vx);
    write_reg(REG_VERT_STEP_Y, vy);
    write_reg(REG_VERT_STEP_Z, vz);
  endtask

  task automatic send_random(int count);
    repeat (count) send_pixel(IN_W'($urandom), IN_W'($urandom));
  endtask

  task automatic test_reset_view();
    send_pixel(12'h000, 12'h000);
    send_pixel(12'h800, 12'h800);
    send_pixel(12'h7ff, 12'h7ff);
    send_pixel(12'h800, 12'h7ff);
    send_pixel(12'h7ff, 12'h800);
    send_pixel(12'hfff, 12'h001);
    wait_drained();
  endtask

  task automatic test_invalid_rays();
    // zero ray, then a ray pointing straight down
    load_view(0, 0, 0, 0, 0, 0, 0, 0);
    send_pixel(12'h123, 12'h7ff);
    wait_drained();
    write_reg(REG_ORIGIN_Z, -32'sd65536);
    send_pixel(12'h000, 12'h000);
    send_pixel(12'h800, 12'h800);
    wait_drained();
  endtask

  task automatic test_clipping();
    // small height and wide steps push offsets past the range
    load_view(32'sd100 << 16, -(32'sd100 << 16), 32'sd1 << 12, 32'sd1 << 20,
              -(32'sd1 << 20), 32'sd3 << 16, 32'sd1 << 18, -(32'sd1 << 10));
    send_pixel(12'h000, 12'h000);
    send_pixel(12'h7ff, 12'h800);
    send_pixel(12'h800, 12'h7ff);
    send_pixel(12'h001, 12'hfff);
    wait_drained();
  endtask

  task automatic test_extreme_regs();
    load_view(32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000,
              32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000);
    send_pixel(12'h800, 12'h800);
    send_pixel(12'h7ff, 12'h7ff);
    send_random(40);
    wait_drained();
    load_view(32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
              32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff);
    send_pixel(12'h800, 12'h7ff);
    send_random(40);
    wait_drained();
  endtask

  task automatic test_random_views(int phases, int per_phase);
    int k;
    for (k = 0; k < phases; k++) begin
      if (k % 4 == 3)
        load_view($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                  $urandom, $urandom);
      else
        load_view($signed($urandom_range(0, 1 << 26)) - (1 << 25),
                  $signed($urandom_range(0, 1 << 26)) - (1 << 25),
                  $signed($urandom_range(0, 1 << 27)) - (1 << 25),
                  $signed($urandom_range(0, 1 << 18)) - (1 << 17),
                  $signed($urandom_range(0, 1 << 18)) - (1 << 17),
                  $signed($urandom_range(0, 1 << 18)) - (1 << 17),
                  $signed($urandom_range(0, 1 << 18)) - (1 << 17),
                  $signed($urandom_range(0, 1 << 16)) - (1 << 15));
      send_random(per_phase);
      wait_drained();
    end
  endtask

  initial begin
    view_reg[REG_ORIGIN_X] = 0;
    view_reg[REG_ORIGIN_Y] = 0;
    view_reg[REG_ORIGIN_Z] = 17629184;
    view_reg[REG_HORIZ_STEP_X] = 65536;
    view_reg[REG_HORIZ_STEP_Y] = 0;
    view_reg[REG_VERT_STEP_X] = 0;
    view_reg[REG_VERT_STEP_Y] = 65536;
    view_reg[REG_VERT_STEP_Z] = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);
    test_reset_view();
    send_random(60);
    wait_drained();
    test_invalid_rays();
    test_clipping();
    test_extreme_regs();
    test_random_views(8, 90);
    if (errors == 0) begin
      $display("** omni_unwarp_coordinate_map: PASSED **");
    end else begin
      $display("** omni_unwarp_coordinate_map: FAILED **");
    end
    $finish;
  end

endmodule
